@@ rtl/core/wpcs_pkg.sv @@
package wpcs_pkg;

  localparam int DATA_W = 16;
  localparam int TOL_W = 15;
  localparam int ANG_W = 25;
  localparam int CRD_W = 20;
  localparam int MULB_W = 17;
  localparam int PROD_W = CRD_W + MULB_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int STEP_W = 4;

  localparam int MOD_STEPS = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int MUL_STEPS = 7;

  localparam logic [ANG_W-1:0] TWO_PI_U = 25'd411775;
  localparam logic [ANG_W-1:0] ANG_BIAS = 25'd8647275;
  localparam logic signed [CRD_W-1:0] TWO_PI_S = 20'sd411775;
  localparam logic signed [CRD_W-1:0] PI_Q16 = 20'sd205887;
  localparam logic signed [CRD_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [CRD_W-1:0] CORDIC_X0 = 20'sd39797;
  localparam logic signed [MULB_W-1:0] GAIN_POS = 17'sd26214;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  localparam logic [TOL_W-1:0] TOL_RESET = 15'd26;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t ex;
    data_t ey;
    data_t eh;
  } err_t;

  typedef enum logic [2:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_TARGET_H = 3'd2,
    REG_TOL_X    = 3'd3,
    REG_TOL_Y    = 3'd4,
    REG_TOL_H    = 3'd5
  } reg_idx_t;

  function automatic logic signed [CRD_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    case (i)
      4'd0:    atan_q16 = 20'sd51472;
      4'd1:    atan_q16 = 20'sd30386;
      4'd2:    atan_q16 = 20'sd16055;
      4'd3:    atan_q16 = 20'sd8150;
      4'd4:    atan_q16 = 20'sd4091;
      4'd5:    atan_q16 = 20'sd2047;
      4'd6:    atan_q16 = 20'sd1024;
      4'd7:    atan_q16 = 20'sd512;
      4'd8:    atan_q16 = 20'sd256;
      4'd9:    atan_q16 = 20'sd128;
      4'd10:   atan_q16 = 20'sd64;
      4'd11:   atan_q16 = 20'sd32;
      4'd12:   atan_q16 = 20'sd16;
      4'd13:   atan_q16 = 20'sd8;
      4'd14:   atan_q16 = 20'sd4;
      4'd15:   atan_q16 = 20'sd2;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

  function automatic data_t sat_w(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      sat_w = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      sat_w = SAT_LO[DATA_W-1:0];
    end else begin
      sat_w = v[DATA_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/waypoint_p_control_settle.sv @@
// Proportional waypoint controller with a settling window. Each pose request
// (x, y, heading in signed Q8.8) is compared with the target registers; the
// position error is scaled by 0.8 and rotated into the body frame by the
// measured heading, the heading error is scaled by 1.5, and all commands
// saturate to 16 bits. The settled flag is high when every error triple in
// the window of the last WINDOW requests lies within the tolerance registers.
// A pose request passes through angle reduction, a quadrant fold, sixteen
// CORDIC iterations, seven steps of the shared multiplier and a scan of
// each of the n triples held in the window (n from 1 to WINDOW); the next
// request is taken only once the result has been handed to the output
// register. A clear request empties the window and returns no result.
module waypoint_p_control_settle #(
  parameter int WINDOW = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  wpcs_pkg::data_t     in_pose_x,
  input  wpcs_pkg::data_t     in_pose_y,
  input  wpcs_pkg::data_t     in_pose_heading,
  output logic                out_valid,
  input  logic                out_ready,
  output wpcs_pkg::data_t     out_cmd_vx,
  output wpcs_pkg::data_t     out_cmd_vy,
  output wpcs_pkg::data_t     out_cmd_wz,
  output logic                out_settled
);
  import wpcs_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FOLD,
    ST_ROT,
    ST_MUL,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  state_t                   state_r;
  logic [STEP_W-1:0]        step_r;
  data_t                    tx_r, ty_r, th_r;
  logic [TOL_W-1:0]         tolx_r, toly_r, tolh_r;
  data_t                    ex_r, ey_r, eh_r;
  logic [ANG_W-1:0]         ang_r;
  logic signed [CRD_W-1:0]  x_r, y_r, z_r;
  logic                     neg_r;
  data_t                    vx_r, vy_r;
  logic signed [ACC_W-1:0]  acc_r;
  data_t                    cmdvx_r, cmdvy_r;
  logic                     ok_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         wpos_r;
  logic [IDX_W-1:0]         scan_idx_r;
  err_t                     rd_r;
  logic                     rd_vld_r;
  logic                     out_valid_r;
  data_t                    outvx_r, outvy_r, outwz_r;
  logic                     outset_r;

  err_t                     win_mem [WINDOW];

  function automatic data_t sat_diff(input data_t a, input data_t b);
    logic signed [DATA_W:0] d;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    sat_diff = sat_w(ACC_W'(d));
  endfunction

  function automatic logic in_tol(input data_t e, input logic [TOL_W-1:0] tol);
    logic [DATA_W:0] mag;
    mag = e[DATA_W-1] ? (DATA_W + 1)'(-$signed({e[DATA_W-1], e})) : {1'b0, e};
    in_tol = (mag <= (DATA_W + 1)'(tol));
  endfunction

  logic                     cfg_we;
  reg_idx_t                 cfg_idx;
  logic [ANG_W-1:0]         mod_cmp;
  logic signed [CRD_W-1:0]  r0, r1, r2;
  logic                     fold_neg;
  logic signed [CRD_W-1:0]  dx, dy, at, xn, yn, zn;
  logic signed [CRD_W-1:0]  mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod, prod_rnd;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [DATA_W+2:0] wz3;
  data_t                    wz;
  logic                     rd_ok;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      REG_TARGET_X: prdata = {{(32 - DATA_W){tx_r[DATA_W-1]}}, tx_r};
      REG_TARGET_Y: prdata = {{(32 - DATA_W){ty_r[DATA_W-1]}}, ty_r};
      REG_TARGET_H: prdata = {{(32 - DATA_W){th_r[DATA_W-1]}}, th_r};
      REG_TOL_X:    prdata = {{(32 - TOL_W){1'b0}}, tolx_r};
      REG_TOL_Y:    prdata = {{(32 - TOL_W){1'b0}}, toly_r};
      REG_TOL_H:    prdata = {{(32 - TOL_W){1'b0}}, tolh_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign mod_cmp = TWO_PI_U << step_r;

  always_comb begin
    r0 = $signed({1'b0, ang_r[CRD_W-2:0]});
    r1 = (r0 > PI_Q16) ? r0 - TWO_PI_S : r0;
    r2 = r1;
    fold_neg = 1'b0;
    if (r1 > HALF_PI_Q16) begin
      r2 = r1 - PI_Q16;
      fold_neg = 1'b1;
    end else if (r1 < -HALF_PI_Q16) begin
      r2 = r1 + PI_Q16;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = atan_q16(step_r);
    if (!z_r[CRD_W-1]) begin
      xn = x_r - dx;
      yn = y_r + dy;
      zn = z_r - at;
    end else begin
      xn = x_r + dx;
      yn = y_r - dy;
      zn = z_r + at;
    end
  end

  always_comb begin
    case (step_r)
      4'd0: begin
        mul_a = CRD_W'(ex_r);
        mul_b = GAIN_POS;
      end
      4'd1: begin
        mul_a = CRD_W'(ey_r);
        mul_b = GAIN_POS;
      end
      4'd2: begin
        mul_a = x_r;
        mul_b = MULB_W'(vx_r);
      end
      4'd3: begin
        mul_a = y_r;
        mul_b = MULB_W'(vy_r);
      end
      4'd4: begin
        mul_a = x_r;
        mul_b = MULB_W'(vy_r);
      end
      4'd5: begin
        mul_a = y_r;
        mul_b = MULB_W'(vx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    prod_rnd = prod + PROD_W'(16384);
    acc_rnd = (acc_r + ACC_W'(32768)) >>> 16;
    wz3 = ($signed({{3{eh_r[DATA_W-1]}}, eh_r}) <<< 1) + (DATA_W + 3)'(eh_r)
          + (DATA_W + 3)'(1);
    wz = sat_w(ACC_W'(wz3 >>> 1));
  end

  assign rd_ok = in_tol(rd_r.ex, tolx_r) & in_tol(rd_r.ey, toly_r) & in_tol(rd_r.eh, tolh_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_FOLD) begin
      win_mem[wpos_r] <= '{ex: ex_r, ey: ey_r, eh: eh_r};
    end
    rd_r <= win_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      tx_r        <= '0;
      ty_r        <= '0;
      th_r        <= '0;
      tolx_r      <= TOL_RESET;
      toly_r      <= TOL_RESET;
      tolh_r      <= TOL_RESET;
      cnt_r       <= '0;
      wpos_r      <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TARGET_X: tx_r <= pwdata[DATA_W-1:0];
          REG_TARGET_Y: ty_r <= pwdata[DATA_W-1:0];
          REG_TARGET_H: th_r <= pwdata[DATA_W-1:0];
          REG_TOL_X:    tolx_r <= pwdata[TOL_W-1:0];
          REG_TOL_Y:    toly_r <= pwdata[TOL_W-1:0];
          REG_TOL_H:    tolh_r <= pwdata[TOL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end

      if (rd_vld_r && !rd_ok) begin
        ok_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_req_type) begin
              cnt_r  <= '0;
              wpos_r <= '0;
            end else begin
              ex_r    <= sat_diff(tx_r, in_pose_x);
              ey_r    <= sat_diff(ty_r, in_pose_y);
              eh_r    <= sat_diff(th_r, in_pose_heading);
              ang_r   <= {in_pose_heading[DATA_W-1], in_pose_heading, 8'd0} + ANG_BIAS;
              step_r  <= STEP_W'(MOD_STEPS - 1);
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (ang_r >= mod_cmp) begin
            ang_r <= ang_r - mod_cmp;
          end
          if (step_r == '0) begin
            state_r <= ST_FOLD;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_FOLD: begin
          z_r    <= r2;
          neg_r  <= fold_neg;
          x_r    <= CORDIC_X0;
          y_r    <= '0;
          step_r <= '0;
          if (wpos_r == IDX_W'(WINDOW - 1)) begin
            wpos_r <= '0;
          end else begin
            wpos_r <= wpos_r + IDX_W'(1);
          end
          if (cnt_r != CNT_W'(WINDOW)) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          z_r <= zn;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            x_r     <= neg_r ? -xn : xn;
            y_r     <= neg_r ? -yn : yn;
            step_r  <= '0;
            state_r <= ST_MUL;
          end else begin
            x_r    <= xn;
            y_r    <= yn;
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_MUL: begin
          case (step_r)
            4'd0: vx_r <= prod_rnd[DATA_W+14:15];
            4'd1: vy_r <= prod_rnd[DATA_W+14:15];
            4'd2: acc_r <= ACC_W'(prod);
            4'd3: acc_r <= acc_r + ACC_W'(prod);
            4'd4: begin
              cmdvx_r <= sat_w(acc_rnd);
              acc_r   <= ACC_W'(prod);
            end
            4'd5: acc_r <= acc_r - ACC_W'(prod);
            4'd6: cmdvy_r <= sat_w(acc_rnd);
            default: ;
          endcase
          if (step_r == STEP_W'(MUL_STEPS - 1)) begin
            scan_idx_r <= '0;
            ok_r       <= 1'b1;
            state_r    <= ST_SCAN;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_SCAN: begin
          rd_vld_r <= 1'b1;
          if (CNT_W'(scan_idx_r) == cnt_r - CNT_W'(1)) begin
            state_r <= ST_LAST;
          end else begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        ST_LAST: begin
          rd_vld_r <= 1'b0;
          state_r  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            outvx_r     <= cmdvx_r;
            outvy_r     <= cmdvy_r;
            outwz_r     <= wz;
            outset_r    <= ok_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_cmd_vx  = outvx_r;
  assign out_cmd_vy  = outvy_r;
  assign out_cmd_wz  = outwz_r;
  assign out_settled = outset_r;

endmodule
